// ----- rtl/core/sapu_pkg.sv -----
// Shared constants, types and register indexes for the sensor average, scale and peak unit.
package sapu_pkg;

   // Item and register field widths
   localparam int CH_W      = 3;
   localparam int SAMPLE_W  = 10;
   localparam int VAL_W     = 23;
   localparam int OFS_W     = 12;
   localparam int SCALE_W   = 11;
   localparam int DIV_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 16;

   // Burst length and sample counter
   localparam int SAMPLES_PER_READING = 8;
   localparam int IDX_W               = 6;

   // Smoothing filter: f = (f*19 + s) / 20, division done by reciprocal multiply.
   // A 19-bit shift keeps the rounding error small enough to be exact for every
   // reachable f*19 + s.
   localparam int FILT_MUL    = 19;
   localparam int FILT_DIV    = 20;
   localparam int MIX_W       = 15;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 15;
   localparam int RECIP       = (2**RECIP_SHIFT + FILT_DIV - 1) / FILT_DIV;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 10'h3FF;

   // Channel map
   localparam logic [CH_W-1:0] FIRST_CUR_CH = 3'd3;
   localparam logic [CH_W-1:0] LAST_CH      = 3'd4;

   // Conversion datapath
   localparam int BASE_W   = 13;
   localparam int PROD_W   = 25;
   localparam int STEP_W   = 5;
   localparam int DIV_STEPS = VAL_W;
   localparam logic signed [VAL_W:0] OUT_MAX = 24'sd4194303;
   localparam logic signed [VAL_W:0] OUT_MIN = -24'sd4194304;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_BIAS       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_SCALE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_DIVISOR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_ZERO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_SCALE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_DIVISOR = 3'd5;

   typedef struct packed {
      logic [CH_W-1:0]     channel;
      logic [SAMPLE_W-1:0] filt;
   } job_type;

   typedef struct packed {
      logic signed [OFS_W-1:0] temp_bias;
      logic [SCALE_W-1:0]      temp_scale;
      logic [DIV_W-1:0]        temp_divisor;
      logic signed [OFS_W-1:0] current_zero;
      logic [SCALE_W-1:0]      current_scale;
      logic [DIV_W-1:0]        current_divisor;
   } cfg_type;

endpackage

// ----- rtl/core/sensor_average_scale_peak_unit.sv -----
// Top level of the sensor average, scale and peak unit: registers, front end, queue, back end.
//
// Use: feed converter samples on the req_ beat channel (channel 0..4, 10-bit sample).
// Each accepted sample on a valid channel advances a burst filter f = (f*19 + s)/20 that
// starts at zero; channels 5..7 are taken and dropped. Every SAMPLES_PER_READING-th valid
// sample ends the burst and one reading beat leaves on rsp_: temperatures (0..2) as
// (f + temp_bias) * temp_scale / temp_divisor, currents (3..4) as
// (f - current_zero) * current_scale / current_divisor, divided toward zero and saturated
// to 23 bits; current beats also carry the held peak of that channel, temperatures zero.
// Path: after the edge that takes the burst's last beat, the job passes through the queue,
// the load, the multiply, the restoring divide and the output register before rsp_valid
// rises, when the back end is free. Throughput: one sample per cycle while req_ready is high;
// the back end converts one reading at a time; the two-entry job queue lets the front keep
// taking samples while the back divides, and req_ready drops only when the queue is full.
// Stall: the reading waits in the output register while rsp_ready is low; the back end
// holds its finished job until that register frees, then the queue and front back up.
// Reset (synchronous, active high): filter, counter and both peaks clear to zero, the
// registers return to offset/zero 0 and scale/divisor 1, and no beat is pending.
// Registers are written through csr_; write them only while idle.
module sensor_average_scale_peak_unit import sapu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CH_W-1:0]         req_channel,
   input  logic [SAMPLE_W-1:0]     req_raw_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CH_W-1:0]         rsp_result_channel,
   output logic signed [VAL_W-1:0] rsp_measured_value,
   output logic signed [VAL_W-1:0] rsp_peak_value,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_job, pop_job;

   // Register file: decode the index, ignore indexes past the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_TEMP_BIAS:       cfg_in.temp_bias       = csr_write_data[OFS_W-1:0];
            REG_TEMP_SCALE:      cfg_in.temp_scale      = csr_write_data[SCALE_W-1:0];
            REG_TEMP_DIVISOR:    cfg_in.temp_divisor    = csr_write_data[DIV_W-1:0];
            REG_CURRENT_ZERO:    cfg_in.current_zero    = csr_write_data[OFS_W-1:0];
            REG_CURRENT_SCALE:   cfg_in.current_scale   = csr_write_data[SCALE_W-1:0];
            REG_CURRENT_DIVISOR: cfg_in.current_divisor = csr_write_data[DIV_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_bias       <= '0;
         cfg_ff.temp_scale      <= SCALE_W'(1);
         cfg_ff.temp_divisor    <= DIV_W'(1);
         cfg_ff.current_zero    <= '0;
         cfg_ff.current_scale   <= SCALE_W'(1);
         cfg_ff.current_divisor <= DIV_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: filter the burst, issue a job at its end
   sapu_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_channel    (req_channel),
      .req_raw_sample (req_raw_sample),
      .push_valid     (push_valid),
      .push_job       (push_job),
      .push_ready     (push_ready)
   );

   // Decouple the front from the slow conversion
   sapu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Back: scale, divide, saturate, hold peaks, drive the result beat
   sapu_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_job            (pop_job),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_channel (rsp_result_channel),
      .rsp_measured_value (rsp_measured_value),
      .rsp_peak_value     (rsp_peak_value)
   );

endmodule

// ----- rtl/core/sapu_front.sv -----
// Front end: takes samples, runs the burst filter and issues one job per finished burst.
module sapu_front import sapu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CH_W-1:0]     req_channel,
   input  logic [SAMPLE_W-1:0] req_raw_sample,
   output logic                push_valid,
   output job_type             push_job,
   input  logic                push_ready
);

   logic [SAMPLE_W-1:0]        filt_ff, filt_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [MIX_W-1:0]           mix;
   logic [MIX_W+RECIP_W-1:0]   recip_prod;
   logic [SAMPLE_W-1:0]        filt_next;
   logic                       accept, ch_ok, last;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign ch_ok     = req_channel <= LAST_CH;
   assign last      = idx_ff == IDX_W'(SAMPLES_PER_READING - 1);

   // filter*19 + sample, then divide by 20 through the reciprocal
   assign mix        = MIX_W'(filt_ff) * MIX_W'(FILT_MUL) + MIX_W'(req_raw_sample);
   assign recip_prod = (MIX_W+RECIP_W)'(mix) * (MIX_W+RECIP_W)'(RECIP);
   assign filt_next  = recip_prod[RECIP_SHIFT +: SAMPLE_W] & SAMPLE_MASK;

   always_comb begin
      filt_in = filt_ff;
      idx_in  = idx_ff;
      if (accept && ch_ok) begin
         if (last) begin
            filt_in = '0;
            idx_in  = '0;
         end else begin
            filt_in = filt_next;
            idx_in  = idx_ff + IDX_W'(1);
         end
      end
   end

   assign push_valid       = accept && ch_ok && last;
   assign push_job.channel = req_channel;
   assign push_job.filt    = filt_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
         idx_ff  <= '0;
      end else begin
         filt_ff <= filt_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

// ----- rtl/core/sapu_queue.sv -----
// Short job queue between the front end and the conversion back end.
module sapu_queue import sapu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]       count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = count_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in    = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (QPTR_W+1)'(1);
      if (do_pop && !do_push) count_in = count_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/sapu_back.sv -----
// Back end: offset, scale, iterative signed divide, saturation, peak hold and result register.
module sapu_back import sapu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  job_type                 pop_job,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CH_W-1:0]         rsp_result_channel,
   output logic signed [VAL_W-1:0] rsp_measured_value,
   output logic signed [VAL_W-1:0] rsp_peak_value
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [CH_W-1:0]          ch_ff, ch_in;
   logic signed [BASE_W-1:0] base_ff, base_in;
   logic [SCALE_W-1:0]       scale_ff, scale_in;
   logic [DIV_W-1:0]         div_ff, div_in;
   logic                     neg_ff, neg_in;
   logic [VAL_W-1:0]         quo_ff, quo_in;
   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [VAL_W-1:0]  peak_ff [2];
   logic signed [VAL_W-1:0]  peak_in [2];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]          rsp_ch_ff, rsp_ch_in;
   logic signed [VAL_W-1:0]  rsp_meas_ff, rsp_meas_in;
   logic signed [VAL_W-1:0]  rsp_peak_ff, rsp_peak_in;

   logic                     is_temp, job_temp, k, out_free;
   logic signed [BASE_W-1:0] filt_s;
   logic [DIV_W-1:0]         div_sel;
   logic signed [PROD_W-1:0] prod, prod_abs;
   logic [DIV_W:0]           trial;
   logic signed [VAL_W:0]    mag_s, val_s;
   logic signed [VAL_W-1:0]  reading, peak_cur;

   assign job_temp  = pop_job.channel < FIRST_CUR_CH;
   assign is_temp   = ch_ff < FIRST_CUR_CH;
   assign k         = ch_ff[0] == 1'b0;   // channel 3 -> slot 0, channel 4 -> slot 1
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = state_ff == S_IDLE;

   assign filt_s  = $signed(BASE_W'(pop_job.filt));
   assign div_sel = job_temp ? cfg.temp_divisor : cfg.current_divisor;

   assign prod     = PROD_W'(base_ff) * PROD_W'($signed({1'b0, scale_ff}));
   assign prod_abs = prod[PROD_W-1] ? -prod : prod;

   // one restoring divide step
   assign trial = {rem_ff, quo_ff[VAL_W-1]};

   // signed, saturated reading
   assign mag_s = $signed({1'b0, quo_ff});
   always_comb begin
      if (neg_ff) val_s = -mag_s;
      else        val_s = mag_s;
      if (val_s > OUT_MAX) val_s = OUT_MAX;
      if (val_s < OUT_MIN) val_s = OUT_MIN;
   end
   assign reading  = val_s[VAL_W-1:0];
   assign peak_cur = peak_ff[k];

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      base_in      = base_ff;
      scale_in     = scale_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      peak_in[0]   = peak_ff[0];
      peak_in[1]   = peak_ff[1];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_meas_in  = rsp_meas_ff;
      rsp_peak_in  = rsp_peak_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               ch_in    = pop_job.channel;
               base_in  = job_temp ? filt_s + BASE_W'(cfg.temp_bias)
                                   : filt_s - BASE_W'(cfg.current_zero);
               scale_in = job_temp ? cfg.temp_scale : cfg.current_scale;
               div_in   = (div_sel == '0) ? DIV_W'(1) : div_sel;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            neg_in   = prod[PROD_W-1];
            quo_in   = prod_abs[VAL_W-1:0];
            rem_in   = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = DIV_W'(trial - {1'b0, div_ff});
               quo_in = {quo_ff[VAL_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DIV_W-1:0];
               quo_in = {quo_ff[VAL_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_meas_in  = reading;
               if (is_temp) begin
                  rsp_peak_in = '0;
               end else if (reading > peak_cur) begin
                  peak_in[k]  = reading;
                  rsp_peak_in = reading;
               end else begin
                  rsp_peak_in = peak_cur;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      base_ff     <= base_in;
      scale_ff    <= scale_in;
      div_ff      <= div_in;
      neg_ff      <= neg_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_meas_ff <= rsp_meas_in;
      rsp_peak_ff <= rsp_peak_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         peak_ff[0]   <= '0;
         peak_ff[1]   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_ff[0]   <= peak_in[0];
         peak_ff[1]   <= peak_in[1];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_channel = rsp_ch_ff;
   assign rsp_measured_value = rsp_meas_ff;
   assign rsp_peak_value     = rsp_peak_ff;

endmodule

// ----- rtl/core/sapu_checker.sv -----
// Port-level checker for the sensor average, scale and peak unit, with its bind.
module sapu_checker import sapu_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [CH_W-1:0]         rsp_result_channel,
   input logic signed [VAL_W-1:0] rsp_measured_value,
   input logic signed [VAL_W-1:0] rsp_peak_value
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_channel)
         && $stable(rsp_measured_value) && $stable(rsp_peak_value))
      else $error("result beat changed while stalled");

   // temperature beats carry no peak
   a_temp_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_channel < FIRST_CUR_CH |-> rsp_peak_value == '0)
      else $error("temperature beat with non-zero peak");

   // the reported peak already includes this reading
   a_peak_ge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_channel == FIRST_CUR_CH || rsp_result_channel == LAST_CH)
         |-> rsp_peak_value >= rsp_measured_value)
      else $error("peak below the reading it reports");

   // nothing pending straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat pending after reset");

endmodule

bind sensor_average_scale_peak_unit sapu_checker u_checker (.*);
